>>> rtl/core/bba_pkg.sv
package bba_pkg;

    localparam int TOP_BLOCKS_DEF      = 32;
    localparam int TOP_ORDER_DEF       = 10;
    localparam int MIN_BLOCK_BYTES_DEF = 128;

    localparam int REQ_W  = 20;
    localparam int OFF_W  = 22;
    localparam int HDR_W  = 7;
    localparam int STAT_W = 2;

    localparam logic [HDR_W-1:0] HDR_RESET = 7'd56;

    localparam logic [1:0] NODE_ABSENT = 2'd0;
    localparam logic [1:0] NODE_FREE   = 2'd1;
    localparam logic [1:0] NODE_ALLOC  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ORD,
        S_SRD,
        S_SCK,
        S_SPLIT0,
        S_SPLIT,
        S_FRD,
        S_FCK,
        S_MRD,
        S_MCK,
        S_MW2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       en;
        logic [1:0] data;
    } t_map_wr;

endpackage

>>> rtl/core/bba_map_ram.sv
module bba_map_ram #(
    parameter int AW = 16
) (
    input  logic             i_clk,
    input  bba_pkg::t_map_wr i_wr,
    input  logic [AW-1:0]    i_waddr,
    input  logic [AW-1:0]    i_raddr,
    output logic [1:0]       o_rdata
);
    import bba_pkg::*;

    logic [1:0] r_mem [2**AW];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_waddr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bba_ctrl.sv
module bba_ctrl #(
    parameter int TOP_BLOCKS      = 32,
    parameter int TOP_ORDER       = 10,
    parameter int MIN_BLOCK_BYTES = 128,
    parameter int TREE_W          = 5,
    parameter int AW              = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_mode,
    input  logic [bba_pkg::REQ_W-1:0]    i_request_bytes,
    input  logic [bba_pkg::OFF_W-1:0]    i_free_offset,
    input  logic [bba_pkg::HDR_W-1:0]    i_hdr,
    input  logic                         i_out_free,
    output logic                         o_idle,
    output logic                         o_done,
    output logic [bba_pkg::OFF_W-1:0]    o_data_offset,
    output logic [bba_pkg::STAT_W-1:0]   o_status,
    output bba_pkg::t_map_wr             o_wr,
    output logic [AW-1:0]                o_waddr,
    output logic [AW-1:0]                o_raddr,
    input  logic [1:0]                   i_rdata
);
    import bba_pkg::*;

    localparam int TN      = TOP_ORDER + 1;
    localparam int LOG_MIN = $clog2(MIN_BLOCK_BYTES);
    localparam int SHIFT   = TOP_ORDER + LOG_MIN;
    localparam int ORD_W   = $clog2(TOP_ORDER + 2);
    localparam int CW      = (SHIFT + 1 > 21) ? SHIFT + 1 : 21;
    localparam int OW      = TREE_W + SHIFT + 1;
    localparam logic [OFF_W-1:0] REM_MASK =
        (SHIFT >= OFF_W) ? '1 : OFF_W'((64'd1 << SHIFT) - 64'd1);
    localparam logic [CW-1:0] TOP_B = CW'(MIN_BLOCK_BYTES) << TOP_ORDER;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [20:0]         r_need, n_need;
    logic [ORD_W-1:0]    r_ord, n_ord;
    logic [ORD_W-1:0]    r_src, n_src;
    logic [TREE_W-1:0]   r_tree, n_tree;
    logic [TN-1:0]       r_node, n_node;
    logic [OFF_W-1:0]    r_rem, n_rem;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [STAT_W-1:0]   r_stat, n_stat;

    logic [20:0]         need;
    logic [OFF_W-1:0]    faddr, tree_full, node_f_w;
    logic [TN-1:0]       node_f, last_k, k_idx;
    logic                aligned;
    logic [OW-1:0]       off_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_need <= n_need;
        r_ord  <= n_ord;
        r_src  <= n_src;
        r_tree <= n_tree;
        r_node <= n_node;
        r_rem  <= n_rem;
        r_off  <= n_off;
        r_stat <= n_stat;
    end

    always_comb begin
        need      = 21'(i_request_bytes) + 21'(i_hdr);
        faddr     = i_free_offset - OFF_W'(i_hdr);
        tree_full = faddr >> SHIFT;
        aligned   = ((r_rem >> (r_ord + LOG_MIN)) << (r_ord + LOG_MIN)) == r_rem;
        node_f_w  = (OFF_W'(1) << (TOP_ORDER - r_ord)) | (r_rem >> (r_ord + LOG_MIN));
        node_f    = TN'(node_f_w);
        last_k    = (TN'(2) << (TOP_ORDER - r_src)) - TN'(1);
        k_idx     = r_node ^ (TN'(1) << (TOP_ORDER - r_ord));
        off_sum   = (OW'(r_tree) << SHIFT) + (OW'(k_idx) << (r_ord + LOG_MIN))
                  + OW'(i_hdr);

        n_state = r_state;
        n_clr   = r_clr;
        n_need  = r_need;
        n_ord   = r_ord;
        n_src   = r_src;
        n_tree  = r_tree;
        n_node  = r_node;
        n_rem   = r_rem;
        n_off   = r_off;
        n_stat  = r_stat;
        o_wr    = '{en: 1'b0, data: NODE_ABSENT};
        o_waddr = '0;
        o_raddr = '0;
        o_idle  = 1'b0;
        o_done  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                o_wr.en   = 1'b1;
                o_wr.data = (r_clr[TN-1:0] == TN'(1)) ? NODE_FREE : NODE_ABSENT;
                o_waddr   = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_off = '0;
                    n_ord = '0;
                    if (i_mode == MODE_ALLOC) begin
                        n_need = need;
                        if (i_request_bytes == '0 || CW'(need) > TOP_B) begin
                            n_stat  = ST_BAD_SIZE;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_ORD;
                        end
                    end else begin
                        n_rem  = faddr & REM_MASK;
                        n_tree = TREE_W'(tree_full);
                        if (i_free_offset < OFF_W'(i_hdr) ||
                            tree_full >= OFF_W'(TOP_BLOCKS)) begin
                            n_stat  = ST_NOT_ALLOC;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_FRD;
                        end
                    end
                end
            end
            S_ORD: begin
                if ((CW'(MIN_BLOCK_BYTES) << r_ord) < CW'(r_need)) begin
                    n_ord = r_ord + 1'b1;
                end else begin
                    n_src   = r_ord;
                    n_tree  = '0;
                    n_node  = TN'(1) << (TOP_ORDER - r_ord);
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                o_raddr = {r_tree, r_node};
                n_state = S_SCK;
            end
            S_SCK: begin
                n_state = S_SRD;
                if (i_rdata == NODE_FREE) begin
                    n_state = S_SPLIT0;
                end else if (r_node != last_k) begin
                    n_node = r_node + 1'b1;
                end else if (r_tree != TREE_W'(TOP_BLOCKS - 1)) begin
                    n_tree = r_tree + 1'b1;
                    n_node = TN'(1) << (TOP_ORDER - r_src);
                end else if (r_src == ORD_W'(TOP_ORDER)) begin
                    n_stat  = ST_NO_SPACE;
                    n_state = S_DONE;
                end else begin
                    n_src  = r_src + 1'b1;
                    n_tree = '0;
                    n_node = TN'(1) << (TOP_ORDER - r_src - 1);
                end
            end
            S_SPLIT0: begin
                o_wr    = '{en: 1'b1, data: NODE_ABSENT};
                o_waddr = {r_tree, r_node};
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                o_wr.en = 1'b1;
                if (r_src > r_ord) begin
                    o_wr.data = NODE_FREE;
                    o_waddr   = {r_tree, r_node[TN-2:0], 1'b1};
                    n_node    = {r_node[TN-2:0], 1'b0};
                    n_src     = r_src - 1'b1;
                end else begin
                    o_wr.data = NODE_ALLOC;
                    o_waddr   = {r_tree, r_node};
                    n_off     = OFF_W'(off_sum);
                    n_stat    = ST_OK;
                    n_state   = S_DONE;
                end
            end
            S_FRD: begin
                o_raddr = {r_tree, node_f};
                n_node  = node_f;
                if (aligned) begin
                    n_state = S_FCK;
                end else begin
                    n_stat  = ST_NOT_ALLOC;
                    n_state = S_DONE;
                end
            end
            S_FCK: begin
                if (i_rdata == NODE_ALLOC) begin
                    n_state = S_MRD;
                end else if (r_ord == ORD_W'(TOP_ORDER)) begin
                    n_stat  = ST_NOT_ALLOC;
                    n_state = S_DONE;
                end else begin
                    n_ord   = r_ord + 1'b1;
                    n_state = S_FRD;
                end
            end
            S_MRD: begin
                o_raddr = {r_tree, r_node ^ TN'(1)};
                if (r_node == TN'(1)) begin
                    o_wr    = '{en: 1'b1, data: NODE_FREE};
                    o_waddr = {r_tree, r_node};
                    n_stat  = ST_OK;
                    n_state = S_DONE;
                end else begin
                    n_state = S_MCK;
                end
            end
            S_MCK: begin
                o_wr.en = 1'b1;
                o_waddr = {r_tree, r_node};
                if (i_rdata == NODE_FREE) begin
                    o_wr.data = NODE_ABSENT;
                    n_state   = S_MW2;
                end else begin
                    o_wr.data = NODE_FREE;
                    n_stat    = ST_OK;
                    n_state   = S_DONE;
                end
            end
            S_MW2: begin
                o_wr    = '{en: 1'b1, data: NODE_ABSENT};
                o_waddr = {r_tree, r_node ^ TN'(1)};
                n_node  = r_node >> 1;
                n_state = S_MRD;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_data_offset = r_off;
    assign o_status      = r_stat;

endmodule

>>> rtl/core/buddy_block_allocator.sv
// Steps: alloc finds the order, scans map entries from that order upward for a
//   free block and splits it down; free probes orders upward for the allocated
//   node, then merges free buddies toward the root.
// One request at a time, set by the single map read port.
// Reset: synchronous; a clearing pass over all 2^(TREE_W+TOP_ORDER+1) map entries
//   (65536 by default) rebuilds the map, input not ready meanwhile.
module buddy_block_allocator #(
    parameter int TOP_BLOCKS      = bba_pkg::TOP_BLOCKS_DEF,
    parameter int TOP_ORDER       = bba_pkg::TOP_ORDER_DEF,
    parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [bba_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic [bba_pkg::OFF_W-1:0]   i_free_offset,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bba_pkg::OFF_W-1:0]   o_data_offset,
    output logic [bba_pkg::STAT_W-1:0]  o_status,
    // APB config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bba_pkg::*;

    // map address = {tree, heap node}, node 0 unused
    localparam int TREE_W = (TOP_BLOCKS > 1) ? $clog2(TOP_BLOCKS) : 1;
    localparam int AW     = TREE_W + TOP_ORDER + 1;

    logic [HDR_W-1:0]  r_hdr;
    logic              r_out_valid;
    logic [OFF_W-1:0]  r_out_off;
    logic [STAT_W-1:0] r_out_stat;

    logic              idle, done;
    logic [OFF_W-1:0]  c_off;
    logic [STAT_W-1:0] c_stat;
    t_map_wr           map_wr;
    logic [AW-1:0]     map_waddr, map_raddr;
    logic [1:0]        map_rdata;

    // header register at addresses 0 to 3 (paddr[2] low); addresses 4 and up read zero
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= HDR_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_hdr <= pwdata[HDR_W-1:0];
        end
    end
    assign prdata = paddr[2] ? 32'd0 : 32'(r_hdr);

    // result register: ctrl finishes into it once it is empty or draining,
    // so a new request can be taken while the last result still waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (done) begin
            r_out_off  <= c_off;
            r_out_stat <= c_stat;
        end
    end

    assign o_in_ready    = idle;
    assign o_out_valid   = r_out_valid;
    assign o_data_offset = r_out_off;
    assign o_status      = r_out_stat;

    bba_ctrl #(
        .TOP_BLOCKS      (TOP_BLOCKS),
        .TOP_ORDER       (TOP_ORDER),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .TREE_W          (TREE_W),
        .AW              (AW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_in_valid && idle),
        .i_mode          (i_mode),
        .i_request_bytes (i_request_bytes),
        .i_free_offset   (i_free_offset),
        .i_hdr           (r_hdr),
        .i_out_free      (!r_out_valid || i_out_ready),
        .o_idle          (idle),
        .o_done          (done),
        .o_data_offset   (c_off),
        .o_status        (c_stat),
        .o_wr            (map_wr),
        .o_waddr         (map_waddr),
        .o_raddr         (map_raddr),
        .i_rdata         (map_rdata)
    );

    bba_map_ram #(
        .AW (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_wr    (map_wr),
        .i_waddr (map_waddr),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

endmodule

>>> rtl/core/bba_checker.sv
module bba_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [bba_pkg::OFF_W-1:0]   o_data_offset,
    input logic [bba_pkg::STAT_W-1:0]  o_status
);
    import bba_pkg::*;

    // one request in flight: accepting drops ready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after a transaction");

    // map clearing keeps the request side closed right after reset
    a_reset_not_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("ready high right after reset");

    a_fail_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_data_offset == '0))
        else $error("failed transaction with nonzero offset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_data_offset) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
